// ===== design/sukt_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package sukt_pkg;

   localparam int KEY_W = 64;
   localparam int POS_W = 4;
   localparam int CNT_W = 5;

   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_REMOVE = 2'd1,
      OP_FIND   = 2'd2,
      OP_READ   = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      STS_DONE = 2'd0,
      STS_DUP  = 2'd1,
      STS_FULL = 2'd2,
      STS_MISS = 2'd3
   } status_type;

   typedef enum logic [0:0] {
      FSM_IDLE = 1'b0,
      FSM_EXEC = 1'b1
   } fsm_type;

   typedef struct packed {
      opcode_type             opcode;
      logic [KEY_W-1:0]       key;
      logic [POS_W-1:0]       position;
   } req_type;

   typedef struct packed {
      status_type             status;
      logic [POS_W-1:0]       found_index;
      logic [KEY_W-1:0]       entry_key;
      logic [CNT_W-1:0]       entry_count;
   } rsp_type;

   // Update command broadcast along the cell row.
   typedef struct packed {
      logic insert;
      logic remove;
   } cell_ctrl_type;

endpackage

`default_nettype wire

// ===== design/sukt_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none

module sukt_cell (
   input  wire                          clock,
   input  wire                          capture,
   input  wire                          occupied,
   input  wire [sukt_pkg::KEY_W-1:0]    key_in,
   input  wire [sukt_pkg::KEY_W-1:0]    op_key,
   input  wire sukt_pkg::cell_ctrl_type ctrl,
   input  wire [sukt_pkg::KEY_W-1:0]    lower_key,
   input  wire                          lower_lt,
   input  wire [sukt_pkg::KEY_W-1:0]    upper_key,
   output logic [sukt_pkg::KEY_W-1:0]   stored_key,
   output logic                         lt_flag,
   output logic                         eq_flag
);

   logic [sukt_pkg::KEY_W-1:0] key_ff;
   logic                       lt_ff;
   logic                       eq_ff;

   // Latch the compare against the incoming key.
   always_ff @(posedge clock) begin
      if (capture) begin
         lt_ff <= occupied && (key_ff < key_in);
         eq_ff <= occupied && (key_ff == key_in);
      end
   end

   // Cells at or above the ordered position shift: up on insert, down on remove.
   always_ff @(posedge clock) begin
      if (ctrl.insert && !lt_ff) begin
         key_ff <= lower_lt ? op_key : lower_key;
      end else if (ctrl.remove && !lt_ff) begin
         key_ff <= upper_key;
      end
   end

   assign stored_key = key_ff;
   assign lt_flag    = lt_ff;
   assign eq_flag    = eq_ff;

endmodule

`default_nettype wire

// ===== design/sorted_unique_key_table_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Sorted table of up to DEPTH unique keys, kept in ascending unsigned order.
// Request channel (req_valid/req_ready/req_data): one transaction carries an
// opcode (insert, remove, find, read at position), a packed key and a position.
// Keys are masked to their low KEY_BYTES bytes on entry.
// Response channel (rsp_valid/rsp_ready/rsp_data): exactly one transaction per
// request, carrying status, index, read key and the entry count afterwards.
// Sequence: on acceptance of a request every cell registers its compare against
// the key on that same edge; then, in the execute state and once the response
// slot is free, the cell row shifts and the response register and rsp_valid load.
// Request flow: a new request is taken only in the idle state, after the compare
// and the shift of the previous one; req_ready is high in the idle state.
// Receiver stall: while the previous response still waits, the block holds in
// the execute state with the table unchanged, and commits once the slot frees.
// Reset: clears the entry count, so the table is empty; key cells keep
// whatever they held, and only cells below the count are ever looked at.
module sorted_unique_key_table_unit #(
   parameter int DEPTH     = 16,
   parameter int KEY_BYTES = 8
) (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      req_valid,
   output logic                     req_ready,
   input  wire sukt_pkg::req_type   req_data,
   output logic                     rsp_valid,
   input  wire                      rsp_ready,
   output sukt_pkg::rsp_type        rsp_data
);

   localparam int IW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int PW = CW + sukt_pkg::POS_W;
   localparam logic [sukt_pkg::KEY_W-1:0] KEY_MASK = (KEY_BYTES >= 8) ?
      {sukt_pkg::KEY_W{1'b1}} :
      ((sukt_pkg::KEY_W'(1) << (8 * KEY_BYTES)) - sukt_pkg::KEY_W'(1));

   // Control state
   sukt_pkg::fsm_type   state_ff, state_in;
   logic [CW-1:0]       count_ff, count_in;
   logic                rsp_valid_ff;

   // Held request
   sukt_pkg::opcode_type         op_ff;
   logic [sukt_pkg::KEY_W-1:0]   key_ff;
   logic [sukt_pkg::POS_W-1:0]   pos_ff;
   logic [sukt_pkg::KEY_W-1:0]   rd_key_ff;
   logic                         rd_ok_ff;
   sukt_pkg::rsp_type            rsp_ff, rsp_in;

   logic                         accept;
   logic                         exec_go;
   logic                         rsp_free;
   logic [sukt_pkg::KEY_W-1:0]   req_key_m;
   logic [IW+3:0]                pos_wide;
   logic [IW-1:0]                pos_idx;
   sukt_pkg::cell_ctrl_type      cell_ctrl;

   logic [sukt_pkg::KEY_W-1:0]   cell_key [DEPTH];
   logic [DEPTH-1:0]             lt_vec;
   logic [DEPTH-1:0]             eq_vec;
   logic [DEPTH-1:0]             bnd_vec;
   logic                         any_eq;
   logic [IW-1:0]                eq_idx;
   logic [CW-1:0]                ins_at;
   logic [IW+3:0]                eq_idx_wide;
   logic [CW+3:0]                ins_at_wide;
   logic [CW+4:0]                count_wide;
   logic                         full;

   assign accept    = req_valid && req_ready;
   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign req_key_m = req_data.key & KEY_MASK;
   assign pos_wide  = (IW + 4)'(req_data.position);
   assign pos_idx   = pos_wide[IW-1:0];

   // ---------------------------------------------------------------------
   // Cell row: each cell holds one key and talks to both neighbors.
   // ---------------------------------------------------------------------
   genvar g;
   generate
      for (g = 0; g < DEPTH; g++) begin : g_cell
         logic [sukt_pkg::KEY_W-1:0] lo_key;
         logic                       lo_lt;
         logic [sukt_pkg::KEY_W-1:0] up_key;
         logic                       occ;

         if (g == 0) begin : g_first
            assign lo_key = key_ff;
            assign lo_lt  = 1'b1;
         end else begin : g_mid
            assign lo_key = cell_key[g-1];
            assign lo_lt  = lt_vec[g-1];
         end

         if (g == DEPTH - 1) begin : g_last
            assign up_key = cell_key[g];
         end else begin : g_body
            assign up_key = cell_key[g+1];
         end

         assign occ = CW'(g) < count_ff;

         sukt_cell u_cell (
            .clock      (clock),
            .capture    (accept),
            .occupied   (occ),
            .key_in     (req_key_m),
            .op_key     (key_ff),
            .ctrl       (cell_ctrl),
            .lower_key  (lo_key),
            .lower_lt   (lo_lt),
            .upper_key  (up_key),
            .stored_key (cell_key[g]),
            .lt_flag    (lt_vec[g]),
            .eq_flag    (eq_vec[g])
         );
      end
   endgenerate

   // ---------------------------------------------------------------------
   // Encode the registered flags. Below-key flags form a prefix, so the
   // insert position is one past the last set flag; at most one equal flag is set.
   // ---------------------------------------------------------------------
   assign bnd_vec = lt_vec & ~({1'b0, lt_vec[DEPTH-1:1]});
   assign any_eq  = |eq_vec;
   assign full    = count_ff == CW'(DEPTH);

   always_comb begin
      eq_idx = '0;
      ins_at = '0;
      for (int i = 0; i < DEPTH; i++) begin
         if (eq_vec[i]) begin
            eq_idx = eq_idx | IW'(i);
         end
         if (bnd_vec[i]) begin
            ins_at = ins_at | CW'(i + 1);
         end
      end
   end

   assign eq_idx_wide = (IW + 4)'(eq_idx);
   assign ins_at_wide = (CW + 4)'(ins_at);
   assign count_wide  = (CW + 5)'(count_in);

   // ---------------------------------------------------------------------
   // Result and table update for the held transaction.
   // ---------------------------------------------------------------------
   always_comb begin
      count_in           = count_ff;
      cell_ctrl          = '0;
      rsp_in.status      = sukt_pkg::STS_DONE;
      rsp_in.found_index = '0;
      rsp_in.entry_key   = '0;
      unique case (op_ff)
         sukt_pkg::OP_INSERT: begin
            if (full) begin
               rsp_in.status = sukt_pkg::STS_FULL;
            end else if (any_eq) begin
               rsp_in.status      = sukt_pkg::STS_DUP;
               rsp_in.found_index = eq_idx_wide[sukt_pkg::POS_W-1:0];
            end else begin
               rsp_in.found_index = ins_at_wide[sukt_pkg::POS_W-1:0];
               cell_ctrl.insert   = exec_go;
               count_in           = count_ff + CW'(1);
            end
         end
         sukt_pkg::OP_REMOVE: begin
            if (any_eq) begin
               rsp_in.found_index = eq_idx_wide[sukt_pkg::POS_W-1:0];
               cell_ctrl.remove   = exec_go;
               count_in           = count_ff - CW'(1);
            end else begin
               rsp_in.status = sukt_pkg::STS_MISS;
            end
         end
         sukt_pkg::OP_FIND: begin
            if (any_eq) begin
               rsp_in.found_index = eq_idx_wide[sukt_pkg::POS_W-1:0];
            end else begin
               rsp_in.status = sukt_pkg::STS_MISS;
            end
         end
         sukt_pkg::OP_READ: begin
            rsp_in.found_index = pos_ff;
            if (rd_ok_ff) begin
               rsp_in.entry_key = rd_key_ff;
            end else begin
               rsp_in.status = sukt_pkg::STS_MISS;
            end
         end
         default: begin
            rsp_in.status = sukt_pkg::STS_MISS;
         end
      endcase
      rsp_in.entry_count = count_wide[sukt_pkg::CNT_W-1:0];
   end

   // ---------------------------------------------------------------------
   // Sequencer
   // ---------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         sukt_pkg::FSM_IDLE: begin
            if (req_valid) begin
               state_in = sukt_pkg::FSM_EXEC;
            end
         end
         sukt_pkg::FSM_EXEC: begin
            if (rsp_free) begin
               state_in = sukt_pkg::FSM_IDLE;
            end
         end
         default: begin
            state_in = sukt_pkg::FSM_IDLE;
         end
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      exec_go   = 1'b0;
      unique case (state_ff)
         sukt_pkg::FSM_IDLE: begin
            req_ready = 1'b1;
         end
         sukt_pkg::FSM_EXEC: begin
            exec_go = rsp_free;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sukt_pkg::FSM_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (exec_go) begin
            count_ff     <= count_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Capture the request and the addressed entry for a read.
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff     <= req_data.opcode;
         key_ff    <= req_key_m;
         pos_ff    <= req_data.position;
         rd_key_ff <= cell_key[pos_idx];
         rd_ok_ff  <= PW'(req_data.position) < PW'(count_ff);
      end
      if (exec_go) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // ---------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("entry count beyond table depth");

   a_keys_unique: assert property (@(posedge clock) disable iff (reset)
      state_ff == sukt_pkg::FSM_EXEC |-> $onehot0(eq_vec))
      else $error("key matched in more than one cell");

   a_keys_sorted: assert property (@(posedge clock) disable iff (reset)
      state_ff == sukt_pkg::FSM_EXEC |-> $onehot0(bnd_vec))
      else $error("cell row out of order");

   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      state_ff == sukt_pkg::FSM_EXEC && rsp_valid_ff && !rsp_ready
      |=> state_ff == sukt_pkg::FSM_EXEC && $stable(count_ff))
      else $error("table changed while response stalled");

   a_insert_count: assert property (@(posedge clock) disable iff (reset)
      cell_ctrl.insert |=> count_ff == $past(count_ff) + CW'(1))
      else $error("insert did not advance count");

endmodule

`default_nettype wire
